FILE: rtl/wmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_pkg
// Shared constants, register codes and width helpers of the window mean
// binarizer.
// ----------------------------------------------------------------------------
package wmb_pkg;

    // pixel and result field widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 10;   // R+G+B sum of one pixel
    localparam int DRAW_W     = 20;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // decision constants
    localparam int LEVEL_MAX  = 255;
    localparam int WHITE_SUM  = 3 * LEVEL_MAX;
    localparam int DRAW_SCALE = 1000 * 1000;
    localparam int WHITE_W    = 10;   // bits of WHITE_SUM

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } t_cfg_idx;

    // bits of one window column sum
    function automatic int csum_bits(input int side);
        return $clog2(side * WHITE_SUM + 1);
    endfunction

    // bits of one window column count
    function automatic int ccnt_bits(input int side);
        return $clog2(side + 1);
    endfunction

    // bits of one job word passed from front to back
    function automatic int job_bits(input int side);
        return side * (csum_bits(side) + ccnt_bits(side)) + PIX_W + 1 + DRAW_W
               + 2 * POS_W + 1;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wmb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_if
// Channel interfaces: pixel input, result output and configuration writes.
// ----------------------------------------------------------------------------
interface wmb_pix_if import wmb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [DRAW_W-1:0] random_draw;

    modport source (output valid, func, red, green, blue, random_draw, input ready);
    modport sink   (input valid, func, red, green, blue, random_draw, output ready);
endinterface

interface wmb_res_if import wmb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             closest_white;
    logic             random_white;
    logic             frame_last;

    modport source (output valid, pos_x, pos_y, closest_white, random_white, frame_last,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, closest_white, random_white, frame_last,
                    output ready);
endinterface

interface wmb_cfg_if import wmb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wmb_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module wmb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push_valid,
    output logic              o_push_ready,
    input  wire logic [W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  wire logic         i_pop_ready,
    output logic [W-1:0]      o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wmb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_front
// Accepts pixel words, tracks the stream position, keeps the line buffer
// and the window of column sums, and issues one job per decided pixel.
// ----------------------------------------------------------------------------
module wmb_front import wmb_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int WINDOW_RADIUS = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wmb_pix_if.sink   i_pix,
    wmb_cfg_if.sink   i_cfg,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output logic [job_bits(2*WINDOW_RADIUS+1)-1:0] o_job
);

    localparam int R      = WINDOW_RADIUS;
    localparam int SIDE   = 2 * R + 1;
    localparam int HIST   = 2 * R;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * R + 1);
    localparam int T_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + R * MAX_WIDTH + R + 1);
    localparam int RW_W   = ROW_W + W_W;
    localparam int XW     = W_W + 2;
    localparam int YW     = ROW_W + 2;
    localparam int CSUM_W = csum_bits(SIDE);
    localparam int CCNT_W = ccnt_bits(SIDE);
    localparam logic [2:0] SETTLE_LEN = 3'd4;

    typedef struct packed {
        logic [SIDE-1:0][CSUM_W-1:0] csum;
        logic [SIDE-1:0][CCNT_W-1:0] ccnt;
        logic [PIX_W-1:0]            ctr;
        logic                        mode;
        logic [DRAW_W-1:0]           draw;
        logic [POS_W-1:0]            x;
        logic [POS_W-1:0]            y;
        logic                        last;
    } t_job;

    typedef logic [HIST-1:0][PIX_W-1:0] t_hist;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_cfg_w;
    logic [CFG_DATA_W-1:0] r_cfg_h;
    logic                  r_cfg_mode;
    logic [2:0]            r_settle;

    // geometry derived from configuration
    logic [W_W-1:0]  r_w;
    logic [H_W-1:0]  r_h;
    logic [T_W-1:0]  r_pix;
    logic [T_W-1:0]  r_lag;
    logic [T_W-1:0]  r_total;
    logic [RW_W-1:0] r_rw;

    // stream position
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [T_W-1:0]   r_t;

    // accept stage
    logic             pix_acc;
    logic             in_frame;
    logic [PIX_W-1:0] cur;
    logic             emit;
    logic             last;
    logic [XW-1:0]    x_full;
    logic [YW-1:0]    y_full;
    logic [SIDE-1:0]  xmask;
    logic [SIDE-1:0]  rmask;
    logic [RW_W-1:0]  t_chk;

    // column stage
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_addr;
    logic [PIX_W-1:0]  r_s1_cur;
    logic [SIDE-1:0]   r_s1_rmask;
    logic [SIDE-1:0]   r_s1_xmask;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic              r_s1_mode;
    logic [POS_W-1:0]  r_s1_x;
    logic [POS_W-1:0]  r_s1_y;
    logic [DRAW_W-1:0] r_s1_draw;
    logic              s1_adv;

    // line buffer: per column, the sums of the last HIST rows
    t_hist             r_mem [MAX_WIDTH];
    t_hist             r_rd;
    logic              r_byp;
    t_hist             r_byp_data;
    t_hist             hist;
    t_hist             wr_data;
    logic [SIDE-1:0][PIX_W-1:0] cvals;
    logic [CSUM_W-1:0] csum;
    logic [CCNT_W-1:0] ccnt;

    // window of column sums, newest column at the top index
    logic [CSUM_W-1:0] r_win_sum [SIDE];
    logic [CCNT_W-1:0] r_win_cnt [SIDE];
    logic [PIX_W-1:0]  r_win_ctr [SIDE];
    t_job              job;

    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 11'd1024;
            r_cfg_h    <= 11'd1024;
            r_cfg_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WIDTH:  r_cfg_w    <= i_cfg.data;
                CFG_HEIGHT: r_cfg_h    <= i_cfg.data;
                CFG_MODE:   r_cfg_mode <= i_cfg.data[0];
                default:    ;
            endcase
        end
    end

    // settle window after reset or a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_LEN;
        end else if (i_cfg.valid) begin
            r_settle <= SETTLE_LEN;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // geometry pipeline, at most one product per register
    always_ff @(posedge i_clk) begin
        if (r_cfg_w == '0) begin
            r_w <= W_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            r_w <= W_W'(MAX_WIDTH);
        end else begin
            r_w <= W_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            r_h <= H_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            r_h <= H_W'(MAX_HEIGHT);
        end else begin
            r_h <= H_W'(r_cfg_h);
        end
        r_pix   <= T_W'(r_w * r_h);
        r_lag   <= T_W'(R * r_w + R);
        r_total <= r_pix + r_lag;
        r_rw    <= RW_W'(r_row * r_w);
    end

    // classify the incoming word
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_settle == '0) && (!r_s1_valid || s1_adv);
    assign in_frame    = (r_t < r_pix);
    assign cur         = (in_frame && !i_pix.func) ?
                         PIX_W'(i_pix.red) + PIX_W'(i_pix.green) + PIX_W'(i_pix.blue) : '0;
    assign emit        = (r_t >= r_lag);
    assign last        = (r_t == r_total - T_W'(1));
    assign t_chk       = r_rw + RW_W'(r_col);

    // decided pixel position and bound masks
    always_comb begin
        logic [XW-1:0] cand;
        int            kk;
        x_full = '0;
        kk     = 0;
        for (int k = R; k >= 0; k--) begin
            cand = XW'(r_col) + XW'(k) * XW'(r_w);
            if (cand >= XW'(R)) begin
                x_full = cand - XW'(R);
                kk     = k;
            end
        end
        y_full = YW'(r_row) - YW'(R) - YW'(kk);
        for (int j = 0; j < SIDE; j++) begin
            xmask[j] = (x_full + XW'(j) >= XW'(R)) &&
                       (x_full + XW'(j) < XW'(r_w) + XW'(R));
            rmask[j] = (YW'(r_row) + YW'(j) >= YW'(2 * R)) &&
                       (YW'(r_row) + YW'(j) < YW'(r_h) + YW'(2 * R));
        end
    end

    // stream counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_t   <= '0;
        end else if (r_settle == 3'd1) begin
            if (W_W'(r_col) >= r_w || t_chk >= RW_W'(r_total)) begin
                r_col <= '0;
                r_row <= '0;
                r_t   <= '0;
            end else begin
                r_t <= T_W'(t_chk);
            end
        end else if (pix_acc) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
                r_t   <= '0;
            end else begin
                r_t <= r_t + 1'b1;
                if (W_W'(r_col) + W_W'(1) >= r_w) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // column stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv && (r_s1_addr == r_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // column stage payload
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_addr  <= r_col;
            r_s1_cur   <= cur;
            r_s1_rmask <= rmask;
            r_s1_xmask <= xmask;
            r_s1_emit  <= emit;
            r_s1_last  <= last;
            r_s1_mode  <= r_cfg_mode;
            r_s1_x     <= POS_W'(x_full);
            r_s1_y     <= POS_W'(y_full);
            r_s1_draw  <= i_pix.random_draw;
            r_byp_data <= wr_data;
        end
    end

    // line buffer read and write-back
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (pix_acc) begin
            r_rd <= r_mem[r_col];
        end
    end

    // build the new column and its masked sum
    assign hist = r_byp ? r_byp_data : r_rd;
    always_comb begin
        for (int i = 0; i < HIST; i++) begin
            cvals[i] = hist[i];
        end
        cvals[HIST] = r_s1_cur;
        for (int i = 0; i < HIST; i++) begin
            wr_data[i] = cvals[i+1];
        end
        csum = '0;
        for (int i = 0; i < SIDE; i++) begin
            csum = csum + (r_s1_rmask[i] ? CSUM_W'(cvals[i]) : '0);
        end
        ccnt = CCNT_W'($countones(r_s1_rmask));
    end

    assign s1_adv = r_s1_valid && (!r_s1_emit || i_job_ready);

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SIDE; j++) begin
                r_win_sum[j] <= '0;
                r_win_cnt[j] <= '0;
                r_win_ctr[j] <= '0;
            end
        end else if (s1_adv) begin
            for (int j = 0; j < SIDE - 1; j++) begin
                r_win_sum[j] <= r_win_sum[j+1];
                r_win_cnt[j] <= r_win_cnt[j+1];
                r_win_ctr[j] <= r_win_ctr[j+1];
            end
            r_win_sum[SIDE-1] <= csum;
            r_win_cnt[SIDE-1] <= ccnt;
            r_win_ctr[SIDE-1] <= cvals[R];
        end
    end

    // job word: window after this shift, masked by column bounds
    always_comb begin
        for (int j = 0; j < SIDE - 1; j++) begin
            job.csum[j] = r_s1_xmask[j] ? r_win_sum[j+1] : '0;
            job.ccnt[j] = r_s1_xmask[j] ? r_win_cnt[j+1] : '0;
        end
        job.csum[SIDE-1] = r_s1_xmask[SIDE-1] ? csum : '0;
        job.ccnt[SIDE-1] = r_s1_xmask[SIDE-1] ? ccnt : '0;
        job.ctr  = r_win_ctr[R+1];
        job.mode = r_s1_mode;
        job.draw = r_s1_draw;
        job.x    = r_s1_x;
        job.y    = r_s1_y;
        job.last = r_s1_last;
    end

    assign o_job_valid = r_s1_valid && r_s1_emit;
    assign o_job       = job;

`ifndef SYNTH
    a_no_accept_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |-> (r_settle == '0))
        else $error("word accepted while geometry settles");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle == '0) |-> (W_W'(r_col) < r_w))
        else $error("column counter beyond width");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle == '0) |-> (r_t < r_total))
        else $error("stream position beyond frame length");
`endif

endmodule
`default_nettype wire

FILE: rtl/wmb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_back
// Sums the window, or takes the centre pixel when the mode bit is clear, forms both
// threshold decisions and holds the result word in the output register.
// ----------------------------------------------------------------------------
module wmb_back import wmb_pkg::*; #(
    parameter int WINDOW_RADIUS = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire logic [job_bits(2*WINDOW_RADIUS+1)-1:0] i_job,
    wmb_res_if.source o_res
);

    localparam int SIDE   = 2 * WINDOW_RADIUS + 1;
    localparam int CSUM_W = csum_bits(SIDE);
    localparam int CCNT_W = ccnt_bits(SIDE);
    localparam int WSUM_W = $clog2(SIDE * SIDE * WHITE_SUM + 1);
    localparam int CNT_W  = $clog2(SIDE * SIDE + 1);
    localparam int DN_W   = DRAW_W + CNT_W;
    localparam int M1_W   = WSUM_W + DRAW_W;
    localparam int M2_W   = DN_W + WHITE_W;
    localparam int PROD_W = (M1_W > M2_W) ? M1_W : M2_W;

    typedef struct packed {
        logic [SIDE-1:0][CSUM_W-1:0] csum;
        logic [SIDE-1:0][CCNT_W-1:0] ccnt;
        logic [PIX_W-1:0]            ctr;
        logic                        mode;
        logic [DRAW_W-1:0]           draw;
        logic [POS_W-1:0]            x;
        logic [POS_W-1:0]            y;
        logic                        last;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } t_tag;

    t_job              job;
    logic [WSUM_W-1:0] sum_b;
    logic [CNT_W-1:0]  sum_n;
    logic              en_a;
    logic              en_b;
    logic              en_c;
    logic              en_d;

    // window sum stage
    logic              r_a_v;
    logic [WSUM_W-1:0] r_a_b;
    logic [CNT_W-1:0]  r_a_n;
    logic [DRAW_W-1:0] r_a_draw;
    t_tag              r_a_tag;

    // product stage
    logic              r_b_v;
    logic [PROD_W-1:0] r_b_m1;
    logic [DN_W-1:0]   r_b_dn;
    logic [WSUM_W:0]   r_b_2b;
    logic [WSUM_W:0]   r_b_wn;
    t_tag              r_b_tag;

    // scale stage
    logic              r_c_v;
    logic              r_c_cw;
    logic [PROD_W-1:0] r_c_m1;
    logic [PROD_W-1:0] r_c_m2;
    t_tag              r_c_tag;

    // output register
    logic              r_d_v;
    logic              r_d_cw;
    logic              r_d_rw;
    t_tag              r_d_tag;

    assign job = i_job;

    // stall chain
    assign en_d        = !r_d_v || o_res.ready;
    assign en_c        = !r_c_v || en_d;
    assign en_b        = !r_b_v || en_c;
    assign en_a        = !r_a_v || en_b;
    assign o_job_ready = en_a;

    // add the column sums and counts
    always_comb begin
        sum_b = '0;
        sum_n = '0;
        for (int j = 0; j < SIDE; j++) begin
            sum_b = sum_b + WSUM_W'(job.csum[j]);
            sum_n = sum_n + CNT_W'(job.ccnt[j]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_job_valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_b    <= job.mode ? sum_b : WSUM_W'(job.ctr);
            r_a_n    <= job.mode ? sum_n : CNT_W'(1);
            r_a_draw <= job.draw;
            r_a_tag  <= '{x: job.x, y: job.y, last: job.last};
        end
        if (en_b) begin
            r_b_m1  <= PROD_W'(r_a_b * DRAW_W'(DRAW_SCALE));
            r_b_dn  <= DN_W'(r_a_draw * r_a_n);
            r_b_2b  <= {r_a_b, 1'b0};
            r_b_wn  <= (WSUM_W+1)'(r_a_n * WHITE_W'(WHITE_SUM));
            r_b_tag <= r_a_tag;
        end
        if (en_c) begin
            r_c_cw  <= !(r_b_2b < r_b_wn);
            r_c_m1  <= r_b_m1;
            r_c_m2  <= PROD_W'(r_b_dn * WHITE_W'(WHITE_SUM));
            r_c_tag <= r_b_tag;
        end
        if (en_d) begin
            r_d_cw  <= r_c_cw;
            r_d_rw  <= (r_c_m1 > r_c_m2);
            r_d_tag <= r_c_tag;
        end
    end

    assign o_res.valid         = r_d_v;
    assign o_res.pos_x         = r_d_tag.x;
    assign o_res.pos_y         = r_d_tag.y;
    assign o_res.closest_white = r_d_cw;
    assign o_res.random_white  = r_d_rw;
    assign o_res.frame_last    = r_d_tag.last;

endmodule
`default_nettype wire

FILE: rtl/window_mean_binarizer_5x5.sv
`default_nettype none
// Path of a decision: column stage, job queue, then the window sum, product, scale and output registers.
// Throughput: one word per cycle unless the settle window or result back-pressure holds the input.
// After a register write, or after reset, input is held off while the frame geometry is
// recomputed; configuration writes are always taken.
// Reset is synchronous, active low; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// window_mean_binarizer_5x5
// Local mean threshold binarization over a square window of pixel sums.
// ----------------------------------------------------------------------------
module window_mean_binarizer_5x5 import wmb_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int WINDOW_RADIUS = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wmb_pix_if.sink   i_pix,
    wmb_cfg_if.sink   i_cfg,
    wmb_res_if.source o_res
);

    localparam int JOB_W = job_bits(2 * WINDOW_RADIUS + 1);

    logic             job_push_valid;
    logic             job_push_ready;
    logic [JOB_W-1:0] job_push;
    logic             job_pop_valid;
    logic             job_pop_ready;
    logic [JOB_W-1:0] job_pop;

    // front: position tracking, line buffer, window
    wmb_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (i_cfg),
        .o_job_valid (job_push_valid),
        .i_job_ready (job_push_ready),
        .o_job       (job_push)
    );

    // job queue
    wmb_fifo #(
        .W     (JOB_W),
        .DEPTH (4)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_push_valid),
        .o_push_ready (job_push_ready),
        .i_push_data  (job_push),
        .o_pop_valid  (job_pop_valid),
        .i_pop_ready  (job_pop_ready),
        .o_pop_data   (job_pop)
    );

    // back: window sum and decisions
    wmb_back #(
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_pop_valid),
        .o_job_ready (job_pop_ready),
        .i_job       (job_pop),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

FILE: dv/tb_window_mean_binarizer_5x5.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_window_mean_binarizer_5x5
// Self-checking bench for the window mean binarizer. Frames of random pixels
// and flush words go in. A local model keeps the line store, the counters and
// the registers, and predicts each pixel decision. Results are checked in
// order, field by field. Both sides stall at random, and the bench sweeps the
// frame geometry, the window mode and the clamp limits.
// ----------------------------------------------------------------------------
module tb_window_mean_binarizer_5x5;
    import wmb_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int RAD        = 2;
    localparam int STORE_ROWS = 2 * RAD + 2;
    localparam int DRAIN      = 12;      // cycles past the last result
    localparam int WD_LIMIT   = 5000;    // cycles with no handshake at all
    localparam int HOLD_LEN   = 300;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             closest_white;
        logic             random_white;
        logic             frame_last;
    } t_decision;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wmb_pix_if pix ();
    wmb_cfg_if cfg ();
    wmb_res_if res ();

    window_mean_binarizer_5x5 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .i_cfg   (cfg.sink),
        .o_res   (res.source)
    );

    always #1 i_clk = ~i_clk;

    // model state: registers, line store of pixel sums, stream counters
    logic [CFG_DATA_W-1:0] reg_w, reg_h;
    logic                  reg_mode;
    logic [PIX_W-1:0]      sum_store [STORE_ROWS*MAXW];
    int unsigned           cur_col, cur_row;

    t_decision decisions_due [$];
    int errors, words_sent, decisions_seen, frames_sent;
    bit calm, hold_req;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the model by one word, queue the decision it produces
    function automatic void predict_decision(logic func, logic [CH_W-1:0] r,
                                             logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                                             logic [DRAW_W-1:0] draw);
        int unsigned w, h, pixels, lag, total, t, p, x, y;
        longint unsigned acc, cnt;
        int ny, nx;
        t_decision d;
        w = clamp_dim(reg_w, MAXW);
        h = clamp_dim(reg_h, MAXH);
        pixels = w * h;
        lag = RAD * w + RAD;
        total = pixels + lag;
        if (cur_col >= w || cur_row > total / w) begin
            cur_col = 0;
            cur_row = 0;
        end
        t = cur_row * w + cur_col;
        if (t >= total) begin
            cur_col = 0;
            cur_row = 0;
            t = 0;
        end
        if (t < pixels)
            sum_store[(cur_row % STORE_ROWS) * MAXW + cur_col] = func ? '0 : r + g + b;
        if (t >= lag) begin
            p = t - lag;
            y = p / w;
            x = p % w;
            acc = 0;
            cnt = 0;
            if (!reg_mode) begin
                acc = sum_store[(y % STORE_ROWS) * MAXW + x];
                cnt = 1;
            end else begin
                for (int dy = -RAD; dy <= RAD; dy++)
                    for (int dx = -RAD; dx <= RAD; dx++) begin
                        ny = int'(y) + dy;
                        nx = int'(x) + dx;
                        if (ny >= 0 && nx >= 0 && ny < int'(h) && nx < int'(w)) begin
                            acc += sum_store[(ny % STORE_ROWS) * MAXW + nx];
                            cnt++;
                        end
                    end
            end
            d.pos_x = x[POS_W-1:0];
            d.pos_y = y[POS_W-1:0];
            d.closest_white = !(2 * acc < WHITE_SUM * cnt);
            d.random_white = acc * DRAW_SCALE > longint'(draw) * WHITE_SUM * cnt;
            d.frame_last = (p == pixels - 1);
            decisions_due = {decisions_due, d};
        end
        if (t + 1 >= total) begin
            cur_col = 0;
            cur_row = 0;
        end else begin
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
            end
        end
    endfunction

    // result receiver: random stalls, calm stretches, long hold-off on request
    int hold_left;
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else if (calm) begin
            res.ready <= 1'b1;
        end else begin
            res.ready <= ($urandom_range(99) >= 24);
        end
    end

    // result checker and watchdog
    int quiet_cycles;
    always @(posedge i_clk) begin
        t_decision exp_d, got;
        if (i_rst_n && res.valid && res.ready) begin
            got = '{res.pos_x, res.pos_y, res.closest_white, res.random_white,
                    res.frame_last};
            decisions_seen++;
            if (decisions_due.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, got.pos_x, got.pos_y);
                errors++;
            end else begin
                exp_d = decisions_due.pop_front();
                if (got !== exp_d) begin
                    $display("%0t: mismatch expected x=%0d y=%0d cw=%0b rw=%0b last=%0b",
                             $time, exp_d.pos_x, exp_d.pos_y, exp_d.closest_white,
                             exp_d.random_white, exp_d.frame_last);
                    $display("%0t:          actual   x=%0d y=%0d cw=%0b rw=%0b last=%0b",
                             $time, got.pos_x, got.pos_y, got.closest_white,
                             got.random_white, got.frame_last);
                    errors++;
                end
            end
        end
        if ((pix.valid && pix.ready) || (cfg.valid && cfg.ready) || (res.valid && res.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     decisions_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // send one word, with a one-cycle gap before it now and then unless calm
    task automatic send_word(logic func, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b, logic [DRAW_W-1:0] draw);
        if (!calm && $urandom_range(99) < 31) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.func <= func;
        pix.red <= r;
        pix.green <= g;
        pix.blue <= b;
        pix.random_draw <= draw;
        do @(posedge i_clk); while (!pix.ready);
        predict_decision(func, r, g, b, draw);
        words_sent++;
    endtask

    task automatic stop_words();
        pix.valid <= 1'b0;
    endtask

    // wait out every due result plus the pipeline tail
    task automatic drain();
        stop_words();
        @(posedge i_clk);
        while (decisions_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_w = val;
            CFG_HEIGHT: reg_h = val;
            CFG_MODE:   reg_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, bit m);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_MODE, m);
    endtask

    function automatic logic [DRAW_W-1:0] pick_draw();
        case ($urandom_range(9))
            0: return 0;
            1: return DRAW_SCALE;
            2: return $urandom_range(2**DRAW_W - 1, DRAW_SCALE);
            default: return $urandom_range(DRAW_SCALE);
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom;
        endcase
    endfunction

    // one well-formed frame; noise flips the word type at random
    task automatic send_frame(int noise_pct);
        int unsigned w, h, pixels, total;
        logic func;
        w = clamp_dim(reg_w, MAXW);
        h = clamp_dim(reg_h, MAXH);
        pixels = w * h;
        total = pixels + RAD * w + RAD;
        for (int unsigned i = 0; i < total; i++) begin
            func = (i >= pixels);
            if ($urandom_range(99) < noise_pct) func = ~func;
            send_word(func, pick_level(), pick_level(), pick_level(), pick_draw());
        end
        frames_sent++;
    endtask

    // extremes, in-frame flush, pixel in a flush slot, draws at and past the range
    task automatic test_directed();
        logic [DRAW_W-1:0] draws [4] = '{0, DRAW_SCALE, DRAW_SCALE + 1, 2**DRAW_W - 1};
        set_geometry(4, 3, 1'b1);
        for (int i = 0; i < 22; i++) begin
            case (i)
                0, 5:    send_word(1'b0, 8'hff, 8'hff, 8'hff, draws[i % 4]);
                1, 6:    send_word(1'b0, 8'h00, 8'h00, 8'h00, draws[i % 4]);
                2:       send_word(1'b1, 8'hff, 8'hff, 8'hff, draws[2]);
                12, 15:  send_word(1'b0, 8'hff, 8'h80, 8'h01, draws[i % 4]);
                default: send_word(i >= 12, pick_level(), pick_level(), pick_level(),
                                   draws[i % 4]);
            endcase
        end
        frames_sent++;
    endtask

    task automatic test_centre_mode();
        set_geometry(3, 2, 1'b0);
        send_frame(0);
        send_frame(10);
    endtask

    // clamped geometry: zero sizes, then the all-ones width and height on short
    // runs that the next geometry change restarts
    task automatic test_clamps();
        set_geometry(0, 0, 1'b1);
        send_frame(0);
        set_geometry(2**CFG_DATA_W - 1, 1, 1'b1);
        for (int i = 0; i < 30; i++)
            send_word(1'b0, pick_level(), pick_level(), pick_level(), pick_draw());
        set_geometry(1, 2**CFG_DATA_W - 1, 1'b0);
        for (int i = 0; i < 30; i++)
            send_word(1'b0, pick_level(), pick_level(), pick_level(), pick_draw());
    endtask

    // a width change that leaves the counters outside the frame
    task automatic test_midframe_restart();
        set_geometry(6, 6, 1'b1);
        for (int i = 0; i < 10; i++)
            send_word(1'b0, pick_level(), pick_level(), pick_level(), pick_draw());
        drain();
        write_reg(CFG_WIDTH, 2);
        send_frame(0);
    endtask

    // receiver holds off while words keep coming, then sender waits for all
    task automatic test_backpressure();
        set_geometry(8, 8, 1'b1);
        calm = 1'b1;
        hold_req = 1'b1;
        send_frame(0);
        calm = 1'b0;
        for (int i = 0; i < 30; i++)
            send_word(1'b0, pick_level(), pick_level(), pick_level(), pick_draw());
        stop_words();
        while (decisions_due.size() != 0) @(posedge i_clk);
        // finish the frame that the pause split
        for (int i = 30; i < 82; i++)
            send_word(i >= 64, pick_level(), pick_level(), pick_level(), pick_draw());
        frames_sent++;
    endtask

    task automatic test_random();
        while (words_sent < 450) begin
            set_geometry($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1));
            send_frame($urandom_range(3) == 0 ? 10 : 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.func = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        pix.random_draw = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_WIDTH;
        cfg.data = '0;
        res.ready = 1'b0;
        reg_w = 1024;
        reg_h = 1024;
        reg_mode = 1'b1;
        cur_col = 0;
        cur_row = 0;
        foreach (sum_store[k]) sum_store[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_centre_mode();
        test_clamps();
        test_midframe_restart();
        test_backpressure();
        test_random();
        drain();

        $display("Covered %0d frames, %0d words in, %0d decisions checked,", frames_sent,
                 words_sent, decisions_seen);
        $display("both window modes, clamped sizes, mid-frame restart and long stalls.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/wmb_pkg.sv
rtl/wmb_if.sv
rtl/wmb_fifo.sv
rtl/wmb_front.sv
rtl/wmb_back.sv
rtl/window_mean_binarizer_5x5.sv
dv/tb_window_mean_binarizer_5x5.sv
